@@ src/ntsw_pkg.sv @@
// ----------------------------------------------------------------------------
// ntsw_pkg
// shared types, word codes and word list builder for the number to speech
// word sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package ntsw_pkg;

    localparam int MAX_WORDS = 7;

    // speech dictionary word codes
    localparam logic [7:0] W_ZERO     = 8'd31;
    localparam logic [7:0] W_TEEN0    = 8'd10;
    localparam logic [7:0] W_TENS0    = 8'd18;
    localparam logic [7:0] W_HUNDRED  = 8'd28;
    localparam logic [7:0] W_THOUSAND = 8'd29;
    localparam logic [7:0] W_AND      = 8'd60;

    localparam logic [3:0] DIGIT_MAX  = 4'd9;

    // digit counts with a meaning of their own
    localparam logic [2:0] CNT_ONE   = 3'd1;
    localparam logic [2:0] CNT_TWO   = 3'd2;
    localparam logic [2:0] CNT_THREE = 3'd3;
    localparam logic [2:0] CNT_FOUR  = 3'd4;

    typedef logic [MAX_WORDS-1:0][7:0] t_words;

    typedef struct packed {
        t_words     words;
        logic [2:0] count;
        logic       silent;
    } t_word_list;

    function automatic logic [3:0] sat_digit(input logic [3:0] d);
        return (d > DIGIT_MAX) ? DIGIT_MAX : d;
    endfunction

    function automatic t_word_list build_words(
        input logic [2:0] cnt,
        input logic [3:0] th_raw,
        input logic [3:0] hu_raw,
        input logic [3:0] te_raw,
        input logic [3:0] un_raw
    );
        t_word_list res;
        logic [2:0] n;
        logic [3:0] th;
        logic [3:0] hu;
        logic [3:0] te;
        logic [3:0] un;
        th = sat_digit(th_raw);
        hu = sat_digit(hu_raw);
        te = sat_digit(te_raw);
        un = sat_digit(un_raw);
        res.words  = '0;
        res.silent = 1'b0;
        n = 3'd0;
        if (cnt == CNT_ONE) begin
            res.words[n] = (un == 4'd0) ? W_ZERO : {4'd0, un};
            n = n + 3'd1;
        end else if (cnt == CNT_TWO || cnt == CNT_THREE || cnt == CNT_FOUR) begin
            if (cnt == CNT_FOUR && th != 4'd0) begin
                res.words[n] = {4'd0, th};
                n = n + 3'd1;
                res.words[n] = W_THOUSAND;
                n = n + 3'd1;
            end
            if ((cnt == CNT_THREE || cnt == CNT_FOUR) && hu != 4'd0) begin
                res.words[n] = {4'd0, hu};
                n = n + 3'd1;
                res.words[n] = W_HUNDRED;
                n = n + 3'd1;
                res.words[n] = W_AND;
                n = n + 3'd1;
            end
            if (te == 4'd1) begin
                res.words[n] = W_TEEN0 + {4'd0, un};
                n = n + 3'd1;
            end else begin
                if (te != 4'd0) begin
                    res.words[n] = W_TENS0 + {4'd0, te};
                    n = n + 3'd1;
                end
                if (un != 4'd0) begin
                    res.words[n] = {4'd0, un};
                    n = n + 3'd1;
                end
            end
        end
        if (n == 3'd0) begin
            res.silent = 1'b1;
            res.count  = 3'd1;
        end else begin
            res.count = n;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ src/number_to_speech_word_sequencer.sv @@
// ----------------------------------------------------------------------------
// number_to_speech_word_sequencer
// turns a decimal number of one to four digits into the speech dictionary
// words that say it, one word per handshake
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  number  | in        | i_valid / o_stall  | i_digit_count, i_digit_thousands,
//          |           |                    | i_digit_hundreds, i_digit_tens,
//          |           |                    | i_digit_units
//  word    | out       | o_valid / i_stall  | o_word_index, o_silent, o_last
//
//  a number is held in the input register, decoded into its full word list in
//  one pass and loaded into the word buffer, which shifts out one word a
//  cycle while i_stall is low; one number gives 1 to 7 words
//  an accepted number passes the input register, then the word buffer
//  the next number is decoded while the last word of this one is delivered,
//  so single-word numbers stream at one per cycle while i_stall is low
//  reset (synchronous, active low) empties both stages; a stalled word holds
//
`default_nettype none

module number_to_speech_word_sequencer (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // number channel
    input  wire logic                    i_valid,
    output      logic                    o_stall,
    input  wire logic [2:0]              i_digit_count,
    input  wire logic [3:0]              i_digit_thousands,
    input  wire logic [3:0]              i_digit_hundreds,
    input  wire logic [3:0]              i_digit_tens,
    input  wire logic [3:0]              i_digit_units,
    // word channel
    output      logic                    o_valid,
    input  wire logic                    i_stall,
    output      logic [7:0]              o_word_index,
    output      logic                    o_silent,
    output      logic                    o_last
);
    import ntsw_pkg::*;

    // input register
    logic       r_in_valid;
    logic [2:0] r_cnt;
    logic [3:0] r_th;
    logic [3:0] r_hu;
    logic [3:0] r_te;
    logic [3:0] r_un;

    // word buffer, slot 0 drives the output
    logic       r_out_valid;
    t_words     r_words;
    logic [2:0] r_left;
    logic       r_silent;

    t_word_list n_list;
    logic       out_take;
    logic       buf_load;
    logic       in_take;

    // decode of the held number
    assign n_list = build_words(r_cnt, r_th, r_hu, r_te, r_un);

    assign out_take = r_out_valid && !i_stall;
    // buffer is free when empty or its last word leaves this cycle
    assign buf_load = r_in_valid && (!r_out_valid || (out_take && r_left == 3'd1));
    // input register frees when empty or handing its number to the buffer
    assign o_stall  = r_in_valid && !buf_load;
    assign in_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (buf_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cnt <= i_digit_count;
            r_th  <= i_digit_thousands;
            r_hu  <= i_digit_hundreds;
            r_te  <= i_digit_tens;
            r_un  <= i_digit_units;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_left      <= 3'd0;
        end else if (buf_load) begin
            r_out_valid <= 1'b1;
            r_left      <= n_list.count;
        end else if (out_take) begin
            r_out_valid <= (r_left != 3'd1);
            r_left      <= r_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (buf_load) begin
            r_words  <= n_list.words;
            r_silent <= n_list.silent;
        end else if (out_take) begin
            // shift the next word into slot 0
            r_words  <= {8'd0, r_words[MAX_WORDS-1:1]};
        end
    end

    assign o_valid      = r_out_valid;
    assign o_word_index = r_words[0];
    assign o_silent     = r_silent;
    assign o_last       = (r_left == 3'd1);

    // a live buffer always has a word left
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_left != 3'd0)
        else $error("word buffer valid with no words left");

    // a silent result is the only result of its number and carries no word
    a_silent_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_silent |-> o_last && o_word_index == 8'd0)
        else $error("silent result not alone");

    // spoken words never have index zero
    a_word_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_silent |-> o_word_index != 8'd0)
        else $error("empty word emitted");

    // a number is never cut short: after a taken word that is not last, more follow
    a_no_cut: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=> o_valid)
        else $error("word sequence cut short");

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// drives decimal numbers of one to four digits into the number to speech word
// sequencer, predicts the spoken words of each one and checks every word that
// comes out, in order, under random gaps and stalls on both channels
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import ntsw_pkg::*;

    // run limit in clock cycles, far above the slowest legal run
    localparam int unsigned CYCLE_LIMIT = 500000;
    // cycles to let pass once every expected word has arrived
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_NUMBERS = 385;

    // one expected word
    typedef struct {
        logic [7:0] word_index;
        logic       silent;
        logic       last;
    } t_spoken_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [2:0] i_digit_count = '0;
    logic [3:0] i_digit_thousands = '0;
    logic [3:0] i_digit_hundreds = '0;
    logic [3:0] i_digit_tens = '0;
    logic [3:0] i_digit_units = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_word_index;
    logic       o_silent;
    logic       o_last;

    // words still owed by the block, oldest first
    t_spoken_word pending_words [$];
    int           fail_count = 0;
    int unsigned  cycle_count = 0;
    // when set, neither side idles
    bit           no_idle = 1'b0;
    int           stall_left = 0;

    number_to_speech_word_sequencer i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_digit_count     (i_digit_count),
        .i_digit_thousands (i_digit_thousands),
        .i_digit_hundreds  (i_digit_hundreds),
        .i_digit_tens      (i_digit_tens),
        .i_digit_units     (i_digit_units),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_word_index      (o_word_index),
        .o_silent          (o_silent),
        .o_last            (o_last)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // word prediction
    // ------------------------------------------------------------------------

    // digits above nine count as nine
    function automatic logic [3:0] clip_digit(input logic [3:0] d);
        if (d > 4'd9) begin
            return 4'd9;
        end
        return d;
    endfunction

    // spells one number and appends its words to the pending list
    function automatic void spell_number(
        input logic [2:0] cnt,
        input logic [3:0] th_raw,
        input logic [3:0] hu_raw,
        input logic [3:0] te_raw,
        input logic [3:0] un_raw
    );
        logic [7:0]   said [$];
        logic [3:0]   th;
        logic [3:0]   hu;
        logic [3:0]   te;
        logic [3:0]   un;
        t_spoken_word w;
        bit           multi;
        th = clip_digit(th_raw);
        hu = clip_digit(hu_raw);
        te = clip_digit(te_raw);
        un = clip_digit(un_raw);
        multi = (cnt >= CNT_TWO) && (cnt <= CNT_FOUR);
        // a lone digit is always spoken, zero included
        if (cnt == CNT_ONE) begin
            said.push_back((un == 4'd0) ? W_ZERO : {4'd0, un});
        end
        if (multi && cnt == CNT_FOUR && th != 4'd0) begin
            said.push_back({4'd0, th});
            said.push_back(W_THOUSAND);
        end
        // hundreds always bring "and", even with nothing after
        if (multi && cnt != CNT_TWO && hu != 4'd0) begin
            said.push_back({4'd0, hu});
            said.push_back(W_HUNDRED);
            said.push_back(W_AND);
        end
        if (multi && te == 4'd1) begin
            said.push_back(W_TEEN0 + {4'd0, un});
        end else if (multi) begin
            if (te != 4'd0) begin
                said.push_back(W_TENS0 + {4'd0, te});
            end
            if (un != 4'd0) begin
                said.push_back({4'd0, un});
            end
        end
        // nothing to say, or a rejected count: one silent word
        if (said.size() == 0) begin
            w.word_index = 8'd0;
            w.silent     = 1'b1;
            w.last       = 1'b1;
            pending_words.push_back(w);
        end else begin
            foreach (said[k]) begin
                w.word_index = said[k];
                w.silent     = 1'b0;
                w.last       = (k == said.size() - 1);
                pending_words.push_back(w);
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // idling
    // ------------------------------------------------------------------------

    // mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 2);
        end
        if (r < 97) begin
            return $urandom_range(3, 6);
        end
        return $urandom_range(10, 30);
    endfunction

    // ------------------------------------------------------------------------
    // number channel driver
    // ------------------------------------------------------------------------

    // presents one number and returns at the edge that takes it;
    // i_valid gets a single nonblocking write per step
    task automatic send_number(
        input logic [2:0] cnt,
        input logic [3:0] th,
        input logic [3:0] hu,
        input logic [3:0] te,
        input logic [3:0] un
    );
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_digit_count     <= cnt;
        i_digit_thousands <= th;
        i_digit_hundreds  <= hu;
        i_digit_tens      <= te;
        i_digit_units     <= un;
        // values read here are those seen by the edge
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        spell_number(cnt, th, hu, te, un);
    endtask

    // ------------------------------------------------------------------------
    // word channel checker and stall generator
    // ------------------------------------------------------------------------

    always @(posedge i_clk) begin : word_check
        t_spoken_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_words.size() == 0) begin
                $error("unexpected word: word_index %0d silent %0b last %0b",
                       o_word_index, o_silent, o_last);
                fail_count++;
            end else begin
                want = pending_words.pop_front();
                if (o_word_index !== want.word_index) begin
                    $error("word_index: expected %0d, got %0d",
                           want.word_index, o_word_index);
                    fail_count++;
                end
                if (o_silent !== want.silent) begin
                    $error("silent: expected %0b, got %0b", want.silent, o_silent);
                    fail_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_last);
                    fail_count++;
                end
            end
        end
        // stall bursts of random length between runs of open cycles
        if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            i_stall <= 1'b0;
            if (!no_idle && $urandom_range(0, 3) == 0) begin
                stall_left <= pick_gap();
            end
        end
    end

    // hard stop if words stop coming
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // lone digits, zero included, saturation and ignored upper digits
    task automatic test_single_digit();
        send_number(CNT_ONE, 4'd0, 4'd0, 4'd0, 4'd0);
        send_number(CNT_ONE, 4'd0, 4'd0, 4'd0, 4'd7);
        send_number(CNT_ONE, 4'd0, 4'd0, 4'd0, 4'd12);
        send_number(CNT_ONE, 4'd15, 4'd15, 4'd15, 4'd3);
    endtask

    // teens, tens words, zero tens or units and the silent double zero
    task automatic test_two_digits();
        send_number(CNT_TWO, 4'd0, 4'd0, 4'd0, 4'd0);
        send_number(CNT_TWO, 4'd0, 4'd0, 4'd0, 4'd5);
        send_number(CNT_TWO, 4'd0, 4'd0, 4'd1, 4'd0);
        send_number(CNT_TWO, 4'd0, 4'd0, 4'd1, 4'd14);
        send_number(CNT_TWO, 4'd0, 4'd0, 4'd2, 4'd0);
        send_number(CNT_TWO, 4'd9, 4'd9, 4'd9, 4'd9);
        send_number(CNT_TWO, 4'd0, 4'd0, 4'd13, 4'd1);
    endtask

    // hundred followed by and, also with nothing after it
    task automatic test_hundreds();
        send_number(CNT_THREE, 4'd0, 4'd1, 4'd0, 4'd0);
        send_number(CNT_THREE, 4'd6, 4'd0, 4'd0, 4'd0);
        send_number(CNT_THREE, 4'd0, 4'd0, 4'd4, 4'd5);
        send_number(CNT_THREE, 4'd0, 4'd9, 4'd1, 4'd3);
        send_number(CNT_THREE, 4'd0, 4'd11, 4'd0, 4'd7);
    endtask

    // full seven-word numbers and skipped zero digits
    task automatic test_thousands();
        send_number(CNT_FOUR, 4'd9, 4'd9, 4'd9, 4'd9);
        send_number(CNT_FOUR, 4'd1, 4'd0, 4'd0, 4'd0);
        send_number(CNT_FOUR, 4'd0, 4'd0, 4'd0, 4'd0);
        send_number(CNT_FOUR, 4'd0, 4'd5, 4'd0, 4'd1);
        send_number(CNT_FOUR, 4'd15, 4'd15, 4'd15, 4'd15);
    endtask

    // counts of zero and above four give one silent word
    task automatic test_rejected_count();
        send_number(3'd0, 4'd3, 4'd2, 4'd1, 4'd8);
        send_number(3'd5, 4'd9, 4'd9, 4'd9, 4'd9);
        send_number(3'd7, 4'd1, 4'd1, 4'd1, 4'd1);
    endtask

    // mostly ordinary numbers, a few oversize digits and bad counts;
    // one stretch runs with no idling on either side
    task automatic test_random_numbers();
        logic [2:0] cnt;
        logic [3:0] d [4];
        for (int n = 0; n < RANDOM_NUMBERS; n++) begin
            no_idle = (n >= 150 && n < 210);
            if ($urandom_range(0, 99) < 5) begin
                cnt = 3'($urandom_range(4, 7));
                if (cnt == CNT_FOUR) begin
                    cnt = 3'd0;
                end
            end else begin
                cnt = 3'($urandom_range(1, 4));
            end
            foreach (d[k]) begin
                if ($urandom_range(0, 9) == 0) begin
                    d[k] = 4'($urandom_range(10, 15));
                end else begin
                    d[k] = 4'($urandom_range(0, 9));
                end
            end
            send_number(cnt, d[0], d[1], d[2], d[3]);
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_digit();
        test_two_digits();
        test_hundreds();
        test_thousands();
        test_rejected_count();
        test_random_numbers();
        i_valid <= 1'b0;

        // let every owed word arrive, then watch for strays
        while (pending_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
src/ntsw_pkg.sv
src/number_to_speech_word_sequencer.sv
tb/sv/testbench.sv
